>>> rtl/page_frame_bitmap_allocator_assert.svh
// Assertion macros for the page frame bitmap allocator.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PFBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfba assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PFBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfba assertion failed");
`else
`define PFBA_ASSERT_IMPL(label, ante, cons)
`define PFBA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/pfba_pkg.sv
// Shared types, constants and a helper function for the page frame bitmap allocator.
// No dependencies; used by page_frame_bitmap_allocator and its testbench.
`default_nettype none

package pfba_pkg;

  localparam int PAGES       = 4096;
  localparam int WORD_BITS   = 32;
  localparam int NWORDS      = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = $clog2(NWORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int PAGE_W      = 12;
  localparam int CNT_W       = 13;
  localparam int TOTAL_RESET = 4096;

  typedef enum logic [2:0] {
    REQ_ALLOC         = 3'd0,
    REQ_FREE          = 3'd1,
    REQ_MARK_USED     = 3'd2,
    REQ_MARK_FREE     = 3'd3,
    REQ_MARK_ALL_USED = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_RANGE = 2'd1,
    ST_NO_FREE_PAGE = 2'd2,
    ST_UNCHANGED    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [PAGE_W-1:0] page_number;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] granted_page;
    logic [CNT_W-1:0]  pages_in_use;
  } rsp_t;

  // Lowest clear bit of a bitmap word; zero when the word is full.
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> rtl/page_frame_bitmap_allocator.sv
// Top level of the first-fit bitmap page frame allocator.
// Depends on pfba_pkg and page_frame_bitmap_allocator_assert.svh.
`default_nettype none

// How to use this block:
// A request word (cmd) is taken at a rising edge where start is high and busy
// is low. Every request yields exactly one result word on result, marked by a
// one-cycle done strobe; the receiver cannot stall, so the word is gone after
// that cycle. busy drops in the same cycle that done is shown, so the next
// request can be issued while the previous result is on the ports.
// The managed page count register is written over the cfg channel (cfg_valid
// with cfg_ready, which is always high) and should only change while idle.
// Requests decided from the register alone (mark all used, out of range page,
// unknown request, alloc with no managed pages) finish at the accepting
// edge. Free and the mark requests do one bitmap read, then the write-back in
// S_SINGLE. An alloc scans from bitmap word 0 and stops at the first word with
// a free page below the limit, or at the last word within the limit.
// The alloc scan reads one bitmap word per cycle from the word memory, which
// has one read and one write port. Reset leaves every page marked used and
// the count at PAGES. The all-ones reset state, and the state after mark all
// used, is held by one valid flop per bitmap word rather than by a clearing
// pass; a word that is not valid reads as all ones, so the block is ready
// right after reset.

module page_frame_bitmap_allocator (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire pfba_pkg::cmd_t           cmd,
  output logic                          done,
  output pfba_pkg::rsp_t                result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [pfba_pkg::CNT_W-1:0] cfg_data
);

`include "page_frame_bitmap_allocator_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SINGLE
  } state_t;

  state_t state;

  logic [pfba_pkg::CNT_W-1:0]     managed_pages;
  logic [pfba_pkg::CNT_W-1:0]     used_count;
  logic [pfba_pkg::NWORDS-1:0]    valid;
  logic [2:0]                     in_req;
  logic [pfba_pkg::BIT_W-1:0]     in_bit;
  logic [pfba_pkg::WADDR_W-1:0]   chk_idx;

  // Bitmap word memory, one read and one write port.
  logic [pfba_pkg::WORD_BITS-1:0] mem [pfba_pkg::NWORDS];
  logic [pfba_pkg::WORD_BITS-1:0] rd_q;
  logic                           rd_valid;
  logic [pfba_pkg::WADDR_W-1:0]   mem_raddr;
  logic                           mem_we;
  logic [pfba_pkg::WORD_BITS-1:0] mem_wdata;

  logic [pfba_pkg::CNT_W-1:0]     limit;
  logic [pfba_pkg::CNT_W-1:0]     lim_m1;
  logic [pfba_pkg::WADDR_W-1:0]   last_word;
  logic [pfba_pkg::CNT_W-1:0]     lim_word;
  logic [pfba_pkg::BIT_W-1:0]     lim_bit;
  logic [pfba_pkg::WORD_BITS-1:0] scan_mask;
  logic [pfba_pkg::WORD_BITS-1:0] eff;
  logic [pfba_pkg::WORD_BITS-1:0] scan_word;
  logic                           found;
  logic [pfba_pkg::BIT_W-1:0]     fz;
  logic [pfba_pkg::CNT_W-1:0]     cnt_inc;
  logic [pfba_pkg::CNT_W-1:0]     cnt_dec;
  logic                           page_out;
  logic                           single_bit;
  logic                           single_flip;
  logic [pfba_pkg::WORD_BITS-1:0] single_word;
  logic [pfba_pkg::CNT_W-1:0]     single_cnt;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // The effective limit is the managed page count clamped to the pages held.
  assign limit = (managed_pages < pfba_pkg::CNT_W'(pfba_pkg::PAGES)) ?
                 managed_pages : pfba_pkg::CNT_W'(pfba_pkg::PAGES);
  assign lim_m1    = limit - pfba_pkg::CNT_W'(1);
  assign last_word = lim_m1[pfba_pkg::BIT_W +: pfba_pkg::WADDR_W];
  assign lim_word  = limit >> pfba_pkg::BIT_W;
  assign lim_bit   = limit[pfba_pkg::BIT_W-1:0];

  assign page_out = ({1'b0, cmd.page_number} >= limit);

  // Words never written since reset or mark all used read as fully used.
  assign eff = rd_valid ? rd_q : '1;

  // Pages at or above the limit in the word under test count as used.
  always_comb begin
    if (pfba_pkg::CNT_W'(chk_idx) < lim_word) begin
      scan_mask = '1;
    end else if (pfba_pkg::CNT_W'(chk_idx) == lim_word) begin
      scan_mask = (pfba_pkg::WORD_BITS'(1) << lim_bit) - pfba_pkg::WORD_BITS'(1);
    end else begin
      scan_mask = '0;
    end
  end

  assign scan_word = eff | ~scan_mask;
  assign found     = ~&scan_word;
  assign fz        = pfba_pkg::first_zero(scan_word);

  // The count saturates at both ends, which matters only after the limit moved.
  assign cnt_inc = (used_count < pfba_pkg::CNT_W'(pfba_pkg::PAGES)) ?
                   used_count + pfba_pkg::CNT_W'(1) : used_count;
  assign cnt_dec = (used_count != '0) ? used_count - pfba_pkg::CNT_W'(1) : used_count;

  // Free, mark used and mark free: modify the one bit fetched last cycle.
  always_comb begin
    single_bit = eff[in_bit];
    if (in_req == pfba_pkg::REQ_MARK_USED) begin
      single_flip = !single_bit;
      single_word = eff | (pfba_pkg::WORD_BITS'(1) << in_bit);
      single_cnt  = cnt_inc;
    end else begin
      single_flip = single_bit;
      single_word = eff & ~(pfba_pkg::WORD_BITS'(1) << in_bit);
      single_cnt  = cnt_dec;
    end
  end

  // Read address: the first word of a request on acceptance, then the word
  // after the one under test while scanning.
  always_comb begin
    case (state)
      S_IDLE: begin
        if (cmd.req_type == pfba_pkg::REQ_ALLOC) begin
          mem_raddr = '0;
        end else begin
          mem_raddr = cmd.page_number[pfba_pkg::BIT_W +: pfba_pkg::WADDR_W];
        end
      end
      S_SCAN:  mem_raddr = chk_idx + pfba_pkg::WADDR_W'(1);
      default: mem_raddr = chk_idx;
    endcase
  end

  // Writes happen only in the last cycle of a request, and the next request
  // reads no earlier than the cycle after, so no forwarding is needed.
  assign mem_we = ((state == S_SCAN) && found) || ((state == S_SINGLE) && single_flip);
  assign mem_wdata = (state == S_SCAN) ? (eff | (pfba_pkg::WORD_BITS'(1) << fz)) :
                     single_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[chk_idx] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      valid         <= '0;
      rd_valid      <= 1'b0;
      used_count    <= pfba_pkg::CNT_W'(pfba_pkg::PAGES);
      managed_pages <= pfba_pkg::CNT_W'(pfba_pkg::TOTAL_RESET);
    end else begin
      rd_valid <= valid[mem_raddr];
      if (cfg_valid && cfg_ready) begin
        managed_pages <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            in_req  <= cmd.req_type;
            in_bit  <= cmd.page_number[pfba_pkg::BIT_W-1:0];
            chk_idx <= mem_raddr;
            result.granted_page <= '0;
            result.pages_in_use <= (cmd.req_type == pfba_pkg::REQ_MARK_ALL_USED) ?
                                   limit : used_count;
            case (cmd.req_type)
              pfba_pkg::REQ_ALLOC: begin
                if (limit == '0) begin
                  result.status <= pfba_pkg::ST_NO_FREE_PAGE;
                  done          <= 1'b1;
                end else begin
                  done  <= 1'b0;
                  state <= S_SCAN;
                end
              end
              pfba_pkg::REQ_FREE, pfba_pkg::REQ_MARK_USED, pfba_pkg::REQ_MARK_FREE: begin
                if (page_out) begin
                  result.status <= pfba_pkg::ST_OUT_OF_RANGE;
                  done          <= 1'b1;
                end else begin
                  done  <= 1'b0;
                  state <= S_SINGLE;
                end
              end
              pfba_pkg::REQ_MARK_ALL_USED: begin
                valid         <= '0;
                used_count    <= limit;
                result.status <= pfba_pkg::ST_OK;
                done          <= 1'b1;
              end
              default: begin
                result.status <= pfba_pkg::ST_OUT_OF_RANGE;
                done          <= 1'b1;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_SCAN: begin
          if (found) begin
            valid[chk_idx]      <= 1'b1;
            used_count          <= cnt_inc;
            result.status       <= pfba_pkg::ST_OK;
            result.granted_page <= {chk_idx, fz};
            result.pages_in_use <= cnt_inc;
            done                <= 1'b1;
            state               <= S_IDLE;
          end else if (chk_idx == last_word) begin
            result.status <= pfba_pkg::ST_NO_FREE_PAGE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            done    <= 1'b0;
            chk_idx <= chk_idx + pfba_pkg::WADDR_W'(1);
          end
        end
        S_SINGLE: begin
          if (single_flip) begin
            valid[chk_idx]      <= 1'b1;
            used_count          <= single_cnt;
            result.status       <= pfba_pkg::ST_OK;
            result.pages_in_use <= single_cnt;
          end else begin
            result.status <= pfba_pkg::ST_UNCHANGED;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only ever shown while the block is ready for the next request.
  `PFBA_ASSERT_IMPL(a_done_not_busy, done, !busy)
  // A single-bit request always finishes in the cycle after its S_SINGLE cycle.
  `PFBA_ASSERT_NEXT(a_single_one_cycle, state == S_SINGLE, done && !busy)
  // Only a successful alloc hands out a nonzero page.
  `PFBA_ASSERT_IMPL(a_grant_zero, done && (result.status != pfba_pkg::ST_OK),
                    result.granted_page == '0)
  // The used count never exceeds the number of pages held.
  `PFBA_ASSERT_IMPL(a_count_bound, 1'b1,
                    used_count <= pfba_pkg::CNT_W'(pfba_pkg::PAGES))
  // Bitmap writes come only from a request in flight.
  `PFBA_ASSERT_IMPL(a_write_busy, mem_we, state != S_IDLE)

endmodule

`default_nettype wire

>>> tb/sv/page_frame_bitmap_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap page frame allocator.
// Depends on pfba_pkg and on the page_frame_bitmap_allocator RTL, nothing else.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_tb;

  // Request codes above mark all used are undefined and must be rejected.
  localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
  // Most random page numbers fall into a low window, so that frees and
  // marks land on pages that alloc actually hands out.
  localparam int HOT_WINDOW   = 192;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 140;
  localparam int SHOW_LIMIT   = 10;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  pfba_pkg::cmd_t             cmd_word;
  logic                       done;
  pfba_pkg::rsp_t             result_word;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [pfba_pkg::CNT_W-1:0] cfg_data;

  // Words waiting to be sent, and the index of the next one the driver takes.
  pfba_pkg::cmd_t request_feed[$];
  int             feed_idx = 0;
  // Replies worked out for accepted words, oldest first.
  pfba_pkg::rsp_t pending_replies[$];

  // Shadow copy of the allocator state, updated as each word is accepted.
  logic [pfba_pkg::PAGES-1:0] shadow_used;
  logic [pfba_pkg::CNT_W-1:0] shadow_count;
  logic [pfba_pkg::CNT_W-1:0] shadow_total;

  logic        word_taken;
  int          idle_pct = 0;
  int          err_count = 0;
  int unsigned cycle_count = 0;

  page_frame_bitmap_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd_word),
    .done      (done),
    .result    (result_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow state and returns the expected reply. The
  // usable page limit is the register clamped to PAGES; mark all used loads the
  // count with it, else it moves only when a bit flips, saturating at both ends.
  function automatic pfba_pkg::rsp_t apply_request(input pfba_pkg::cmd_t c);
    pfba_pkg::rsp_t r;
    int   limit;
    int   pg;
    int   i;
    logic found;
    limit = (shadow_total < pfba_pkg::PAGES) ? int'(shadow_total) : pfba_pkg::PAGES;
    pg = int'(c.page_number);
    r.status = pfba_pkg::ST_OK;
    r.granted_page = '0;
    found = 1'b0;
    case (c.req_type)
      pfba_pkg::REQ_ALLOC: begin
        r.status = pfba_pkg::ST_NO_FREE_PAGE;
        for (i = 0; i < limit && !found; i++) begin
          if (!shadow_used[i]) begin
            shadow_used[i] = 1'b1;
            found = 1'b1;
            if (shadow_count < pfba_pkg::PAGES) shadow_count = shadow_count + 1'b1;
            r.granted_page = pfba_pkg::PAGE_W'(i);
            r.status = pfba_pkg::ST_OK;
          end
        end
      end
      pfba_pkg::REQ_FREE, pfba_pkg::REQ_MARK_FREE: begin
        if (pg >= limit) begin
          r.status = pfba_pkg::ST_OUT_OF_RANGE;
        end else if (shadow_used[pg]) begin
          shadow_used[pg] = 1'b0;
          if (shadow_count > 0) shadow_count = shadow_count - 1'b1;
        end else begin
          r.status = pfba_pkg::ST_UNCHANGED;
        end
      end
      pfba_pkg::REQ_MARK_USED: begin
        if (pg >= limit) begin
          r.status = pfba_pkg::ST_OUT_OF_RANGE;
        end else if (!shadow_used[pg]) begin
          shadow_used[pg] = 1'b1;
          if (shadow_count < pfba_pkg::PAGES) shadow_count = shadow_count + 1'b1;
        end else begin
          r.status = pfba_pkg::ST_UNCHANGED;
        end
      end
      pfba_pkg::REQ_MARK_ALL_USED: begin
        // Every bit is set, but the count only covers the managed pages.
        shadow_used = '1;
        shadow_count = pfba_pkg::CNT_W'(limit);
      end
      default: begin
        r.status = pfba_pkg::ST_OUT_OF_RANGE;
      end
    endcase
    r.pages_in_use = shadow_count;
    return r;
  endfunction

  function automatic pfba_pkg::cmd_t make_word(input logic [2:0] req, input int page);
    pfba_pkg::cmd_t c;
    c.req_type = req;
    c.page_number = pfba_pkg::PAGE_W'(page);
    return c;
  endfunction

  // One random request. Frees and marks are weighted so that the bitmap keeps
  // a mix of free and used pages in the low window; a small share of words
  // carry unknown codes or pages anywhere in the 12-bit range.
  function automatic pfba_pkg::cmd_t random_word(input int limit, input int span);
    pfba_pkg::cmd_t c;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 36) begin
      c.req_type = pfba_pkg::REQ_ALLOC;
    end else if (pick < 60) begin
      c.req_type = pfba_pkg::REQ_FREE;
    end else if (pick < 72) begin
      c.req_type = pfba_pkg::REQ_MARK_USED;
    end else if (pick < 92) begin
      c.req_type = pfba_pkg::REQ_MARK_FREE;
    end else if (pick < 95) begin
      c.req_type = pfba_pkg::REQ_MARK_ALL_USED;
    end else begin
      c.req_type = 3'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST));
    end
    pick = $urandom_range(99);
    if (span > 0 && pick < 75) begin
      c.page_number = pfba_pkg::PAGE_W'($urandom_range(span - 1));
    end else if (limit > 0 && pick < 88) begin
      c.page_number = pfba_pkg::PAGE_W'($urandom_range(limit - 1));
    end else begin
      c.page_number = pfba_pkg::PAGE_W'($urandom_range(pfba_pkg::PAGES - 1));
    end
    return c;
  endfunction

  // Fills the feed with about n random words. Now and then a well-formed
  // burst goes in: a run of mark_free over consecutive pages followed by as
  // many allocs, which must hand those pages back in order unless a lower
  // page was already free.
  task automatic queue_random(input int n, input int limit);
    int k;
    int j;
    int base;
    int span;
    k = 0;
    span = (limit < HOT_WINDOW) ? limit : HOT_WINDOW;
    while (k < n) begin
      if (span >= 4 && $urandom_range(99) < 10) begin
        base = $urandom_range(span - 4);
        for (j = 0; j < 4; j++) begin
          request_feed.push_back(make_word(pfba_pkg::REQ_MARK_FREE, base + j));
        end
        for (j = 0; j < 4; j++) begin
          request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC,
                                           $urandom_range(pfba_pkg::PAGES - 1)));
        end
        k += 8;
      end else begin
        request_feed.push_back(random_word(limit, span));
        k++;
      end
    end
  endtask

  // Returns at a falling edge once every queued word has been sent and every
  // reply has been checked. Everything read here changes only at the other
  // edge or later in this step, so the check is free of races.
  task automatic wait_idle();
    do @(negedge clk);
    while (!(feed_idx == request_feed.size() && !start && pending_replies.size() == 0));
  endtask

  // Writes the managed page count; called at a falling edge with the block idle.
  task automatic write_total(input int value);
    cfg_data  <= pfba_pkg::CNT_W'(value);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int total, input int idle, input int n);
    wait_idle();
    write_total(total);
    @(posedge clk);
    idle_pct = idle;
    queue_random(n, (total < pfba_pkg::PAGES) ? total : pfba_pkg::PAGES);
  endtask

  // Driver. A word sits on cmd with start high until the block takes it; the
  // slot is free again once start is low or the word was taken at the last
  // rising edge. Sender idling is drawn per free slot from idle_pct.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (feed_idx < request_feed.size() && $urandom_range(99) >= idle_pct) begin
        cmd_word <= request_feed[feed_idx];
        feed_idx <= feed_idx + 1;
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A result word is checked before a word accepted at the same edge
  // is predicted: busy drops in the done cycle, so both can meet at one edge,
  // and the result always belongs to the older request.
  always @(posedge clk) begin : reply_check
    pfba_pkg::rsp_t want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      if (done) begin
        if (pending_replies.size() == 0) begin
          if (err_count < SHOW_LIMIT) begin
            $display("unexpected result word: status %0d page %0d in use %0d",
                     result_word.status, result_word.granted_page,
                     result_word.pages_in_use);
          end
          err_count++;
        end else begin
          want = pending_replies.pop_front();
          if (result_word.status !== want.status ||
              result_word.granted_page !== want.granted_page ||
              result_word.pages_in_use !== want.pages_in_use) begin
            if (err_count < SHOW_LIMIT) begin
              $display("mismatch: expected status %0d page %0d in use %0d, got %0d %0d %0d",
                       want.status, want.granted_page, want.pages_in_use,
                       result_word.status, result_word.granted_page,
                       result_word.pages_in_use);
            end
            err_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) shadow_total = cfg_data;
      word_taken <= start && !busy;
      if (start && !busy) pending_replies.push_back(apply_request(cmd_word));
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_frame_bitmap_allocator regression: fail");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd_word  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    // Reset leaves every page used, the count full and the register at 4096.
    shadow_used  = '1;
    shadow_count = pfba_pkg::CNT_W'(pfba_pkg::PAGES);
    shadow_total = pfba_pkg::CNT_W'(pfba_pkg::TOTAL_RESET);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Right after reset nothing is free, so the first alloc scans every word.
    // Then the first and last pages are released and taken back, the already
    // set and already clear cases are hit, and unknown codes are rejected.
    request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_USED, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_FREE, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(pfba_pkg::REQ_FREE, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_FREE, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_FREE, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_USED, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(REQ_UNKNOWN_FIRST, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(REQ_UNKNOWN_LAST, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_ALL_USED, 0));

    // With no managed pages, alloc finds nothing and every page is out of
    // range; mark all used then loads the count with zero.
    wait_idle();
    write_total(0);
    @(posedge clk);
    request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_FREE, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_USED, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_FREE, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_ALL_USED, pfba_pkg::PAGES - 1));

    // A register value above PAGES is clamped. The count is zero while the
    // bits are all set, so this free must hold the count at zero.
    wait_idle();
    write_total(2 ** pfba_pkg::CNT_W - 1);
    @(posedge clk);
    request_feed.push_back(make_word(pfba_pkg::REQ_FREE, pfba_pkg::PAGES - 1));
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_USED, pfba_pkg::PAGES - 1));

    // A single managed page: only page 0 can be freed and handed out.
    wait_idle();
    write_total(1);
    @(posedge clk);
    request_feed.push_back(make_word(pfba_pkg::REQ_MARK_FREE, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC, 0));
    request_feed.push_back(make_word(pfba_pkg::REQ_FREE, 1));
    request_feed.push_back(make_word(pfba_pkg::REQ_ALLOC, 0));

    // Random phases over several limits, with and without sender idling.
    run_phase(pfba_pkg::PAGES, 0, 450);
    run_phase(2 ** pfba_pkg::CNT_W - 1, 55, 350);
    run_phase(100, 0, 350);
    run_phase(1, 29, 150);
    run_phase(0, 29, 60);
    run_phase(pfba_pkg::PAGES - 1, 55, 290);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_replies.size() == 0) begin
      $display("page_frame_bitmap_allocator regression: pass");
    end else begin
      $display("page_frame_bitmap_allocator regression: fail");
    end
    $finish;
  end

endmodule

>>> page_frame_bitmap_allocator.f
+incdir+rtl
rtl/pfba_pkg.sv
rtl/page_frame_bitmap_allocator.sv
tb/sv/page_frame_bitmap_allocator_tb.sv
